// File: rtl/core/lkv_pkg.sv
// shared constants, operation codes and status type for the lru key/value store core
// depends on nothing; imported by lkv_ctrl, lkv_datapath and lru_key_value_store_core
package lkv_pkg;

	localparam int MAX_ENTRIES = 64;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int KEY_W       = 32;
	localparam int VAL_W       = 32;
	localparam int CAP_W       = 7;
	localparam int CAP_RESET   = (64 > MAX_ENTRIES) ? MAX_ENTRIES : 64;

	// configuration port
	localparam int APB_AW = 3;
	localparam int APB_DW = 32;
	localparam logic [APB_AW-3:0] REG_CAPACITY = '0;

	// item commands
	localparam logic CMD_ADD    = 1'b0;
	localparam logic CMD_ACCESS = 1'b1;

	// datapath operation for the current cycle
	typedef enum logic [2:0] {
		OP_IDLE,
		OP_LOAD,
		OP_LOOKUP,
		OP_RESOLVE,
		OP_EMIT,
		OP_TOUCH
	} lkv_op_t;

	// datapath status seen by the controller
	typedef struct packed {
		logic scan_done;
		logic is_access;
		logic hit;
		logic out_free;
	} lkv_stat_t;

endpackage

// File: rtl/core/lkv_ctrl.sv
// controller state machine of the lru key/value store core
// depends on lkv_pkg; drives lkv_datapath through lkv_op_t and reads lkv_stat_t
module lkv_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  lkv_pkg::lkv_stat_t stat,
	output lkv_pkg::lkv_op_t   op
);
	import lkv_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOKUP,
		S_RESOLVE,
		S_RESULT,
		S_TOUCH
	} state_t;

	state_t state_q;
	state_t state_next;
	logic   ready_q;
	logic   accept;

	assign accept   = in_valid & ready_q;
	assign in_ready = ready_q;

	always_comb begin
		state_next = state_q;
		op         = OP_IDLE;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					op         = OP_LOAD;
					state_next = S_LOOKUP;
				end
			end
			S_LOOKUP: begin
				op = OP_LOOKUP;
				if (stat.scan_done) begin
					state_next = S_RESOLVE;
				end
			end
			S_RESOLVE: begin
				op         = OP_RESOLVE;
				state_next = stat.is_access ? S_RESULT : S_TOUCH;
			end
			S_RESULT: begin
				op = OP_EMIT;
				if (stat.out_free) begin
					state_next = stat.hit ? S_TOUCH : S_IDLE;
				end
			end
			S_TOUCH: begin
				op = OP_TOUCH;
				if (stat.scan_done) begin
					state_next = S_IDLE;
				end
			end
			default: begin
				state_next = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ready_q <= 1'b1;
		end else begin
			state_q <= state_next;
			ready_q <= (state_next == S_IDLE);
		end
	end

endmodule

// File: rtl/core/lkv_datapath.sv
// datapath of the lru key/value store core: key, value and rank memories, scan, output register
// depends on lkv_pkg; sequenced by lkv_ctrl
module lkv_datapath (
	input  logic                        clk,
	input  logic                        arst_n,
	input  lkv_pkg::lkv_op_t            op,
	input  logic                        item_cmd,
	input  logic [lkv_pkg::KEY_W-1:0]   item_key,
	input  logic [lkv_pkg::VAL_W-1:0]   item_value,
	input  logic                        cfg_we,
	input  logic [lkv_pkg::CAP_W-1:0]   cfg_wdata,
	output logic [lkv_pkg::CNT_W-1:0]   capacity,
	output lkv_pkg::lkv_stat_t          stat,
	output logic                        out_valid,
	output logic                        out_found,
	output logic [lkv_pkg::VAL_W-1:0]   out_value,
	input  logic                        out_ready
);
	import lkv_pkg::*;

	logic [KEY_W-1:0] key_mem  [MAX_ENTRIES];
	logic [VAL_W-1:0] val_mem  [MAX_ENTRIES];
	logic [IDX_W-1:0] rank_mem [MAX_ENTRIES];

	// current item
	logic             cmd_q;
	logic [KEY_W-1:0] key_q;
	logic [VAL_W-1:0] val_q;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] capacity_q;
	logic [CNT_W-1:0] idx_q;

	// memory read stage
	logic             lk_vld_s1;
	logic             tc_vld_s1;
	logic [IDX_W-1:0] rd_idx_s1;
	logic [KEY_W-1:0] key_rd_s1;
	logic [VAL_W-1:0] val_rd_s1;
	logic [IDX_W-1:0] rank_rd_s1;

	// lookup results and touch parameters
	logic             hit_q;
	logic [IDX_W-1:0] hit_slot_q;
	logic [IDX_W-1:0] hit_rank_q;
	logic [IDX_W-1:0] victim_q;
	logic [IDX_W-1:0] slot_q;
	logic [CNT_W-1:0] thresh_q;

	logic             out_valid_q;
	logic             out_found_q;
	logic [VAL_W-1:0] out_value_q;

	logic             scanning;
	logic             issue;
	logic [IDX_W-1:0] rd_addr;
	logic [CNT_W-1:0] last_rank;
	logic             is_full;
	logic             has_room;
	logic             wr_en;
	logic [IDX_W-1:0] wr_addr;
	logic             grow;
	logic [CNT_W-1:0] cap_clamped;
	logic [IDX_W-1:0] rank_new;
	logic             out_free;

	assign scanning  = (op == OP_LOOKUP) || (op == OP_TOUCH);
	assign issue     = scanning && (idx_q < count_q);
	assign rd_addr   = scanning ? idx_q[IDX_W-1:0] : hit_slot_q;
	assign last_rank = count_q - CNT_W'(1);
	assign is_full   = (count_q >= capacity_q) && (count_q != '0);
	assign has_room  = count_q < CNT_W'(MAX_ENTRIES);

	// add: update in place on a hit, else replace the victim or take the next free slot
	always_comb begin
		priority if (hit_q) begin
			wr_addr = hit_slot_q;
		end else if (is_full) begin
			wr_addr = victim_q;
		end else begin
			wr_addr = count_q[IDX_W-1:0];
		end
	end

	assign wr_en = (op == OP_RESOLVE) && (cmd_q == CMD_ADD) && (hit_q || is_full || has_room);
	assign grow  = (op == OP_RESOLVE) && (cmd_q == CMD_ADD) && !hit_q && !is_full && has_room;

	always_comb begin
		priority if (cfg_wdata == '0) begin
			cap_clamped = CNT_W'(1);
		end else if (32'(cfg_wdata) > MAX_ENTRIES) begin
			cap_clamped = CNT_W'(MAX_ENTRIES);
		end else begin
			cap_clamped = CNT_W'(cfg_wdata);
		end
	end

	// entries more recent than the touched one age by one, the touched one becomes rank 0
	always_comb begin
		priority if (rd_idx_s1 == slot_q) begin
			rank_new = '0;
		end else if (CNT_W'(rank_rd_s1) < thresh_q) begin
			rank_new = rank_rd_s1 + IDX_W'(1);
		end else begin
			rank_new = rank_rd_s1;
		end
	end

	assign out_free = !out_valid_q || out_ready;

	// memories
	always_ff @(posedge clk) begin
		key_rd_s1  <= key_mem[rd_addr];
		val_rd_s1  <= val_mem[rd_addr];
		rank_rd_s1 <= rank_mem[rd_addr];
		if (wr_en) begin
			key_mem[wr_addr] <= key_q;
			val_mem[wr_addr] <= val_q;
		end
		if (tc_vld_s1) begin
			rank_mem[rd_idx_s1] <= rank_new;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		rd_idx_s1 <= idx_q[IDX_W-1:0];
		if (op == OP_LOAD) begin
			cmd_q <= item_cmd;
			key_q <= item_key;
			val_q <= item_value;
		end
		if (op == OP_LOOKUP && lk_vld_s1) begin
			if (key_rd_s1 == key_q) begin
				hit_slot_q <= rd_idx_s1;
				hit_rank_q <= rank_rd_s1;
			end
		end
		if (op == OP_LOAD) begin
			victim_q <= '0;
		end else if (op == OP_LOOKUP && lk_vld_s1 && CNT_W'(rank_rd_s1) == last_rank) begin
			victim_q <= rd_idx_s1;
		end
		if (op == OP_RESOLVE) begin
			slot_q <= (cmd_q == CMD_ACCESS) ? hit_slot_q : wr_addr;
			priority if (hit_q) begin
				thresh_q <= CNT_W'(hit_rank_q);
			end else if (is_full) begin
				thresh_q <= last_rank;
			end else begin
				thresh_q <= count_q;
			end
		end
		if (op == OP_EMIT && out_free) begin
			out_found_q <= hit_q;
			out_value_q <= hit_q ? val_rd_s1 : '1;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			capacity_q  <= CNT_W'(CAP_RESET);
			idx_q       <= '0;
			lk_vld_s1   <= 1'b0;
			tc_vld_s1   <= 1'b0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we && count_q == '0) begin
				capacity_q <= cap_clamped;
			end
			if (grow) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (op == OP_LOAD || op == OP_RESOLVE) begin
				idx_q <= '0;
			end else if (issue) begin
				idx_q <= idx_q + CNT_W'(1);
			end
			lk_vld_s1 <= issue && (op == OP_LOOKUP);
			tc_vld_s1 <= issue && (op == OP_TOUCH);
			if (op == OP_LOAD) begin
				hit_q <= 1'b0;
			end else if (op == OP_LOOKUP && lk_vld_s1 && key_rd_s1 == key_q) begin
				hit_q <= 1'b1;
			end
			if (op == OP_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign stat.scan_done = (idx_q >= count_q) && !lk_vld_s1 && !tc_vld_s1;
	assign stat.is_access = (cmd_q == CMD_ACCESS);
	assign stat.hit       = hit_q;
	assign stat.out_free  = out_free;

	assign capacity  = capacity_q;
	assign out_valid = out_valid_q;
	assign out_found = out_found_q;
	assign out_value = out_value_q;

endmodule

// File: rtl/core/lru_key_value_store_core.sv
// top level of the lru key/value store core: stream ports, apb register port
// depends on lkv_pkg, lkv_ctrl and lkv_datapath
//
// channel   direction  handshake          payload
// s_*       in         s_tvalid/s_tready  tuser: cmd; tdata: key, value
// m_*       out        m_tvalid/m_tready  tuser: found; tdata: read_value
// apb       in         psel/penable       capacity register at byte address 0
//
// one item at a time: accept, key scan over the live entries, a resolve state, a
// result state for an access, then on a hit or an add a rank update pass over the
// live entries; both scans go through the single read port of the key and rank
// memories
// reset clears the entry count and the output valid flag; memories keep no reset
// a stalled result holds in the output register; the next item is taken meanwhile
// and waits only if it needs the output register too
module lru_key_value_store_core (
	input  logic                         clk,
	input  logic                         arst_n,
	// item input
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [63:0]                  s_tdata,  // key [31:0], value [63:32]
	input  logic                         s_tuser,  // cmd [0]
	// result output
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [31:0]                  m_tdata,  // read_value [31:0]
	output logic                         m_tuser,  // found [0]
	// register port
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [lkv_pkg::APB_AW-1:0]   paddr,
	input  logic [lkv_pkg::APB_DW-1:0]   pwdata,
	output logic [lkv_pkg::APB_DW-1:0]   prdata,
	output logic                         pready
);
	import lkv_pkg::*;

	lkv_op_t          op;
	lkv_stat_t        stat;
	logic             cfg_sel;
	logic             cfg_we;
	logic [CNT_W-1:0] capacity;

	// register index sits above the byte offset
	assign cfg_sel = (paddr[APB_AW-1:2] == REG_CAPACITY);
	// capacity is only taken while the store is empty, checked in the datapath
	assign cfg_we  = psel & penable & pwrite & pready & cfg_sel;
	assign pready  = 1'b1;
	assign prdata  = cfg_sel ? APB_DW'(capacity) : '0;

	lkv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.stat     (stat),
		.op       (op)
	);

	lkv_datapath u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.item_cmd   (s_tuser),
		.item_key   (s_tdata[31:0]),
		.item_value (s_tdata[63:32]),
		.cfg_we     (cfg_we),
		.cfg_wdata  (pwdata[CAP_W-1:0]),
		.capacity   (capacity),
		.stat       (stat),
		.out_valid  (m_tvalid),
		.out_found  (m_tuser),
		.out_value  (m_tdata),
		.out_ready  (m_tready)
	);

endmodule
